// ===== rtl/smallest_k_selector_assert.svh =====
// Assertion macros for the smallest-k selector RTL.
`ifndef SMALLEST_K_SELECTOR_ASSERT_SVH
`define SMALLEST_K_SELECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SKS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smallest_k_selector check failed");

// Next-cycle implication, checked outside reset.
`define SKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smallest_k_selector check failed");

`endif

// ===== rtl/sks_pkg.sv =====
// Shared constants and types of the smallest-k selector.
package sks_pkg;

  localparam int MAX_KEEP = 32;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(MAX_KEEP + 1);
  localparam int KEEP_W   = 6;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(8);

  localparam logic [ADDR_W-3:0] REG_KEEP_COUNT = '0;

  localparam logic [1:0] OP_HOLD    = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_REPLACE = 2'd2;
  localparam logic [1:0] OP_SHIFT   = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] din;
  } cell_bus_t;

endpackage

// ===== rtl/sks_cfg.sv =====
// APB register block holding the keep count.
module sks_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sks_pkg::ADDR_W-1:0]      paddr,
  input  logic [sks_pkg::DATA_W-1:0]      pwdata,
  output logic [sks_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  output logic [sks_pkg::CNT_W-1:0]       keep_limit
);

  logic [sks_pkg::KEEP_W-1:0] keep_count_r;
  logic [sks_pkg::KEEP_W-1:0] keep_count_nxt;
  logic                       hit;

  assign pready = 1'b1;
  assign hit    = (paddr[sks_pkg::ADDR_W-1:2] == sks_pkg::REG_KEEP_COUNT);

  always_comb begin
    keep_count_nxt = keep_count_r;
    if (psel && penable && pwrite && hit) begin
      keep_count_nxt = pwdata[sks_pkg::KEEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= sks_pkg::KEEP_RESET;
    end else begin
      keep_count_r <= keep_count_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = sks_pkg::DATA_W'(keep_count_r);
    end
  end

  always_comb begin
    if (int'(keep_count_r) > sks_pkg::MAX_KEEP) begin
      keep_limit = sks_pkg::CNT_W'(sks_pkg::MAX_KEEP);
    end else begin
      keep_limit = sks_pkg::CNT_W'(keep_count_r);
    end
  end

endmodule

// ===== rtl/sks_cell.sv =====
// One cell of the descending sorted chain.
module sks_cell (
  input  logic                              clk,
  input  sks_pkg::cell_bus_t                bus,
  input  logic                              occupied,
  input  logic signed [sks_pkg::VAL_W-1:0]  left_val,
  input  logic                              left_ge,
  input  logic signed [sks_pkg::VAL_W-1:0]  right_val,
  input  logic                              right_ge,
  output logic signed [sks_pkg::VAL_W-1:0]  val,
  output logic                              ge
);

  logic signed [sks_pkg::VAL_W-1:0] val_r;
  logic signed [sks_pkg::VAL_W-1:0] val_nxt;

  assign val = val_r;
  assign ge  = occupied && (val_r >= bus.din);

  always_comb begin
    val_nxt = val_r;
    unique case (bus.op)
      sks_pkg::OP_HOLD: begin
        val_nxt = val_r;
      end
      sks_pkg::OP_INSERT: begin
        if (ge) begin
          val_nxt = val_r;
        end else if (left_ge) begin
          val_nxt = bus.din;
        end else begin
          val_nxt = left_val;
        end
      end
      sks_pkg::OP_REPLACE: begin
        if (right_ge) begin
          val_nxt = right_val;
        end else if (ge) begin
          val_nxt = bus.din;
        end else begin
          val_nxt = val_r;
        end
      end
      sks_pkg::OP_SHIFT: begin
        val_nxt = right_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/smallest_k_selector.sv =====
// Top level of the streaming smallest-k selector built on a cell chain.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     in_value, in_end_of_set
//   out_     output     out_valid / out_ready   out_kept_value, out_final_result
//   cfg      input      psel/penable/pready     paddr, pwdata, prdata
//
// While a set is collected one request is taken every cycle; each cell compares it at once.
// After the request marked end of set, the chain shifts toward cell 0 and reports one value
// per cycle while the output is not stalled, until all held values are out; no request is taken then.
// A stalled output holds the chain. Reset is synchronous and empties the chain.
`include "smallest_k_selector_assert.svh"

module smallest_k_selector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sks_pkg::VAL_W-1:0]  in_value,
  input  logic                              in_end_of_set,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sks_pkg::VAL_W-1:0]  out_kept_value,
  output logic                              out_final_result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sks_pkg::ADDR_W-1:0]        paddr,
  input  logic [sks_pkg::DATA_W-1:0]        pwdata,
  output logic [sks_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int N = sks_pkg::MAX_KEEP;

  logic [sks_pkg::CNT_W-1:0]        keep_limit;
  logic [sks_pkg::CNT_W-1:0]        held_count_r, held_count_nxt;
  logic                             drain_r, drain_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic signed [sks_pkg::VAL_W-1:0] out_kept_value_r, out_kept_value_nxt;
  logic                             out_final_result_r, out_final_result_nxt;
  logic                             accept, emit, do_insert, do_replace;
  sks_pkg::cell_bus_t               bus;
  logic signed [sks_pkg::VAL_W-1:0] cell_val [N];
  logic                             cell_ge  [N];

  sks_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .keep_limit (keep_limit)
  );

  assign in_ready   = !drain_r;
  assign accept     = in_valid && in_ready;
  assign emit       = drain_r && (!out_valid_r || out_ready);
  assign do_insert  = accept && (held_count_r < keep_limit);
  assign do_replace = accept && !do_insert && (held_count_r != '0) && (cell_val[0] > in_value);

  always_comb begin
    bus.din = in_value;
    priority if (emit) begin
      bus.op = sks_pkg::OP_SHIFT;
    end else if (do_insert) begin
      bus.op = sks_pkg::OP_INSERT;
    end else if (do_replace) begin
      bus.op = sks_pkg::OP_REPLACE;
    end else begin
      bus.op = sks_pkg::OP_HOLD;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam logic [sks_pkg::CNT_W-1:0] IDX = sks_pkg::CNT_W'(i);
    logic signed [sks_pkg::VAL_W-1:0] left_val, right_val;
    logic                             left_ge, right_ge;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_ge  = 1'b1;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
      assign left_ge  = cell_ge[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_val = '0;
      assign right_ge  = 1'b0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
      assign right_ge  = cell_ge[i+1];
    end

    sks_cell u_cell (
      .clk       (clk),
      .bus       (bus),
      .occupied  (IDX < held_count_r),
      .left_val  (left_val),
      .left_ge   (left_ge),
      .right_val (right_val),
      .right_ge  (right_ge),
      .val       (cell_val[i]),
      .ge        (cell_ge[i])
    );
  end

  always_comb begin
    held_count_nxt = held_count_r;
    drain_nxt      = drain_r;
    if (emit) begin
      held_count_nxt = held_count_r - sks_pkg::CNT_W'(1);
      drain_nxt      = (held_count_r != sks_pkg::CNT_W'(1));
    end else if (accept) begin
      if (do_insert) begin
        held_count_nxt = held_count_r + sks_pkg::CNT_W'(1);
      end
      drain_nxt = in_end_of_set && (held_count_nxt != '0);
    end
  end

  always_comb begin
    out_valid_nxt        = out_valid_r && !out_ready;
    out_kept_value_nxt   = out_kept_value_r;
    out_final_result_nxt = out_final_result_r;
    if (emit) begin
      out_valid_nxt        = 1'b1;
      out_kept_value_nxt   = cell_val[0];
      out_final_result_nxt = (held_count_r == sks_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= '0;
      drain_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      held_count_r <= held_count_nxt;
      drain_r      <= drain_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kept_value_r   <= out_kept_value_nxt;
    out_final_result_r <= out_final_result_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kept_value   = out_kept_value_r;
  assign out_final_result = out_final_result_r;

  `SKS_ASSERT_NOW(a_count_bound, 1'b1, held_count_r <= sks_pkg::CNT_W'(sks_pkg::MAX_KEEP))
  `SKS_ASSERT_NOW(a_drain_nonempty, drain_r, held_count_r != '0)
  `SKS_ASSERT_NEXT(a_final_ends_drain, emit && (held_count_r == sks_pkg::CNT_W'(1)),
                   !drain_r && out_final_result)
  `SKS_ASSERT_NEXT(a_insert_grows, do_insert,
                   held_count_r == $past(held_count_r) + sks_pkg::CNT_W'(1))

endmodule

// ===== test/tb_smallest_k_selector.sv =====
// Self-checking testbench of the streaming smallest-k selector.
module tb_smallest_k_selector;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [sks_pkg::VAL_W-1:0] val_t;

  typedef struct {
    val_t value;
    logic last;
  } request_t;

  typedef struct {
    val_t kept;
    logic fin;
  } report_t;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 2 * sks_pkg::MAX_KEEP + 8;
  localparam int RAND_ITEMS   = 200;
  localparam logic [sks_pkg::ADDR_W-1:0] KEEP_ADDR = {sks_pkg::REG_KEEP_COUNT, 2'b00};

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  val_t                         in_value;
  logic                         in_end_of_set;
  logic                         out_valid;
  logic                         out_ready;
  val_t                         out_kept_value;
  logic                         out_final_result;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [sks_pkg::ADDR_W-1:0]   paddr;
  logic [sks_pkg::DATA_W-1:0]   pwdata;
  logic [sks_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  request_t                   request_q[$];
  report_t                    report_q[$];
  val_t                       held_vals[$];
  logic [sks_pkg::KEEP_W-1:0] keep_setting;
  logic                       req_live;
  int                         send_idle_pct;
  int                         recv_idle_pct;
  int                         error_count;
  int                         cycle_count;

  smallest_k_selector uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_end_of_set    (in_end_of_set),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kept_value   (out_kept_value),
    .out_final_result (out_final_result),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Keeps the held values sorted from largest to smallest; equal values go after older ones.
  function automatic void place_value(val_t v);
    int p;
    p = held_vals.size();
    while (p > 0 && held_vals[p-1] < v) p--;
    held_vals.insert(p, v);
  endfunction

  function automatic void absorb_value(val_t v, logic last);
    int eff_k;
    report_t r;
    eff_k = (keep_setting > sks_pkg::MAX_KEEP) ? sks_pkg::MAX_KEEP : int'(keep_setting);
    if (held_vals.size() < eff_k) begin
      place_value(v);
    end else if (held_vals.size() > 0 && v < held_vals[0]) begin
      void'(held_vals.pop_front());
      place_value(v);
    end
    if (last) begin
      foreach (held_vals[i]) begin
        r.kept = held_vals[i];
        r.fin  = (i == held_vals.size() - 1);
        report_q.insert(report_q.size(), r);
      end
      held_vals.delete();
    end
  endfunction

  always @(posedge clk) begin
    report_t exp_r;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $error("unexpected result: kept_value %0d final_result %0b",
                 out_kept_value, out_final_result);
          error_count++;
        end else begin
          exp_r = report_q.pop_front();
          if (out_kept_value !== exp_r.kept) begin
            $error("kept_value mismatch: expected %0d, actual %0d", exp_r.kept, out_kept_value);
            error_count++;
          end
          if (out_final_result !== exp_r.fin) begin
            $error("final_result mismatch: expected %0b, actual %0b",
                   exp_r.fin, out_final_result);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        absorb_value(in_value, in_end_of_set);
        req_live = 1'b0;
      end
      if (psel && penable && pwrite && pready && paddr == KEEP_ADDR) begin
        keep_setting = pwdata[sks_pkg::KEEP_W-1:0];
      end
    end
  end

  always @(negedge clk) begin
    request_t nxt;
    if (rst_n && !req_live) begin
      if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = request_q.pop_front();
        in_value      <= nxt.value;
        in_end_of_set <= nxt.last;
        in_valid      <= 1'b1;
        req_live = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic void push_item(val_t v, logic last);
    request_t r;
    r.value = v;
    r.last  = last;
    request_q.insert(request_q.size(), r);
  endfunction

  task automatic wait_idle();
    while (request_q.size() != 0 || req_live || report_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_keep(input logic [sks_pkg::KEEP_W-1:0] k);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEEP_ADDR;
    pwdata  <= sks_pkg::DATA_W'(k);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic val_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return val_t'($urandom());
      5, 6:          return val_t'($urandom_range(0, 20)) - 10;
      7: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:       return val_t'($urandom_range(0, 1000)) - 500;
    endcase
  endfunction

  initial begin
    logic [sks_pkg::KEEP_W-1:0] keep_plan[11];
    int rand_sent;
    int plan_idx;
    int set_len;
    int sets;
    logic [sks_pkg::KEEP_W-1:0] k;

    keep_plan = '{6'd32, 6'd63, 6'd1, 6'd0, 6'd3, 6'd8, 6'd33, 6'd16, 6'd2, 6'd31, 6'd5};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value      = '0;
    in_end_of_set = 1'b0;
    out_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    req_live      = 1'b0;
    keep_setting  = sks_pkg::KEEP_RESET;
    send_idle_pct = 24;
    recv_idle_pct = 85;
    error_count   = 0;
    cycle_count   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A short set with both extremes under the reset setting.
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(0, 1'b0);
    push_item(-1, 1'b0);
    push_item(1, 1'b0);
    push_item(5, 1'b1);
    wait_idle();

    // A value equal to the held maximum of a full store is dropped.
    write_keep(6'd2);
    push_item(10, 1'b0);
    push_item(4, 1'b0);
    push_item(4, 1'b0);
    push_item(4, 1'b0);
    push_item(3, 1'b1);
    wait_idle();

    write_keep(6'd0);
    push_item(1, 1'b0);
    push_item(2, 1'b1);
    wait_idle();

    write_keep(6'd1);
    push_item(-7, 1'b1);
    wait_idle();

    // The setting is lowered while a set is still open.
    write_keep(6'd5);
    push_item(9, 1'b0);
    push_item(8, 1'b0);
    push_item(7, 1'b0);
    push_item(6, 1'b0);
    push_item(5, 1'b0);
    wait_idle();
    write_keep(6'd3);
    push_item(1, 1'b1);
    wait_idle();

    rand_sent = 0;
    plan_idx  = 0;
    while (rand_sent < RAND_ITEMS) begin
      if (rand_sent >= 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (rand_sent >= RAND_ITEMS / 3) begin
        send_idle_pct = 85;
        recv_idle_pct = 24;
      end
      k = (plan_idx < 11) ? keep_plan[plan_idx] : sks_pkg::KEEP_W'($urandom_range(0, 63));
      plan_idx = (plan_idx + 1) % 13;
      write_keep(k);
      sets = $urandom_range(1, 3);
      for (int s = 0; s < sets; s++) begin
        set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 12);
        for (int j = 0; j < set_len; j++) begin
          push_item(pick_value(),
                    (j == set_len - 1) && !(s == sets - 1 && $urandom_range(0, 5) == 0));
        end
        rand_sent += set_len;
      end
      wait_idle();
    end

    push_item(pick_value(), 1'b1);
    wait_idle();

    if (error_count == 0 && report_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== smallest_k_selector.f =====
+incdir+rtl
rtl/sks_pkg.sv
rtl/sks_cfg.sv
rtl/sks_cell.sv
rtl/smallest_k_selector.sv
test/tb_smallest_k_selector.sv
